>>> rtl/core/thc_pkg.sv
// Shared types and constants of the tuple hash combiner.
`timescale 1ns / 1ps

package thc_pkg;

    localparam int unsigned HASH_W  = 64;
    localparam int unsigned COUNT_W = 12;

    localparam logic [15:0] MAX_ELEMENTS = 16'd4095;

    localparam logic [HASH_W-1:0] XX_P1      = 64'd11400714785074694791;
    localparam logic [HASH_W-1:0] XX_P2      = 64'd14029467366897019727;
    localparam logic [HASH_W-1:0] XX_P5      = 64'd2870177450012600261;
    localparam logic [HASH_W-1:0] XX_LEN_MIX = 64'd3527539;
    localparam logic [HASH_W-1:0] XX_ALT     = 64'd1546275796;
    localparam logic [HASH_W-1:0] LG_START   = 64'h345678;
    localparam logic [HASH_W-1:0] LG_STEP    = 64'd82520;
    localparam logic [HASH_W-1:0] LG_ADD     = 64'd97531;
    localparam logic [HASH_W-1:0] ALL_ONES   = {HASH_W{1'b1}};

    localparam logic MODE_XX     = 1'b0;
    localparam logic MODE_LEGACY = 1'b1;

    // One classified word from the front to the back.
    typedef struct packed {
        logic               empty_rec;
        logic               first;
        logic               last;
        logic               err;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] left;
        logic [HASH_W-1:0]  lane;
    } thc_word_t;

    function automatic logic [HASH_W-1:0] start_value(input logic mode);
        return (mode == MODE_LEGACY) ? LG_START : XX_P5;
    endfunction

endpackage

>>> rtl/core/thc_front.sv
// Front end: accepts words, saturates the count and tracks record position and error.
`timescale 1ns / 1ps

module thc_front
    import thc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [HASH_W-1:0]  lane_hash,
    input  logic [COUNT_W-1:0] element_count,
    output logic               wr_valid,
    output thc_word_t          wr_word,
    input  logic               wr_full
);

    logic [COUNT_W-1:0] element_index_reg;
    logic               error_seen_reg;

    logic               accept;
    logic [COUNT_W-1:0] count_sat;
    logic               first;
    logic               err_next;
    logic [COUNT_W-1:0] index_next;
    logic               last;
    logic [COUNT_W-1:0] left;

    assign in_stall = wr_full;
    assign accept   = in_valid && !wr_full;
    assign wr_valid = accept;

    always_comb
    begin
        count_sat  = ({4'b0, element_count} > MAX_ELEMENTS) ? MAX_ELEMENTS[COUNT_W-1:0]
                                                            : element_count;
        first      = (element_index_reg == '0);
        err_next   = (!first && error_seen_reg) || (lane_hash == ALL_ONES);
        index_next = element_index_reg + 1'b1;
        // the index wraps at the field width, which also closes the record
        last       = (index_next >= count_sat) || (index_next == '0);
        if (({1'b0, element_index_reg} + 13'd1) < {1'b0, count_sat})
            left = count_sat - 1'b1 - element_index_reg;
        else
            left = '0;

        wr_word.empty_rec = (count_sat == '0);
        wr_word.first     = first;
        wr_word.last      = last;
        wr_word.err       = err_next;
        wr_word.count     = count_sat;
        wr_word.left      = left;
        wr_word.lane      = lane_hash;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_index_reg <= '0;
            error_seen_reg    <= 1'b0;
        end
        else if (accept)
        begin
            if (count_sat == '0 || last)
            begin
                element_index_reg <= '0;
                error_seen_reg    <= 1'b0;
            end
            else
            begin
                element_index_reg <= index_next;
                error_seen_reg    <= err_next;
            end
        end
    end

endmodule

>>> rtl/core/thc_fifo.sv
// Two-entry queue between the front and the back.
`timescale 1ns / 1ps

module thc_fifo
    import thc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    input  thc_word_t wr_word,
    output logic      wr_full,
    output logic      rd_valid,
    output thc_word_t rd_word,
    input  logic      rd_en
);

    localparam int unsigned DEPTH = 2;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    thc_word_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   fill_reg;

    logic do_wr;
    logic do_rd;

    assign wr_full  = (fill_reg == (PTR_W+1)'(DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_word  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && !wr_full;
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                fill_reg <= fill_reg + 1'b1;
            else if (do_rd && !do_wr)
                fill_reg <= fill_reg - 1'b1;
        end
    end

endmodule

>>> rtl/core/thc_back.sv
// Back end: folds words through a shared 32x32 multiplier and finishes the record hash.
`timescale 1ns / 1ps

module thc_back
    import thc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              hash_mode,
    input  logic [HASH_W-1:0] legacy_multiplier,
    input  logic              rd_valid,
    input  thc_word_t         rd_word,
    output logic              rd_en,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [HASH_W-1:0] combined_hash,
    output logic              hash_error
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ROT,
        S_FIN
    } state_t;

    localparam logic [1:0] MSTEP_LAST = 2'd2;

    state_t             state_reg;
    logic [1:0]         mstep_reg;
    logic               second_mul_reg;
    logic [HASH_W-1:0]  op_a_reg;
    logic [HASH_W-1:0]  op_b_reg;
    logic [HASH_W-1:0]  prod_reg;
    logic [HASH_W-1:0]  acc_reg;
    logic [HASH_W-1:0]  rm_reg;
    logic               last_reg;
    logic               err_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               out_valid_reg;
    logic [HASH_W-1:0]  combined_hash_reg;
    logic               hash_error_reg;

    logic [31:0]        mul_x;
    logic [31:0]        mul_y;
    logic [HASH_W-1:0]  mul_p;
    logic [HASH_W-1:0]  prod_next;
    logic [HASH_W-1:0]  start_acc;
    logic [HASH_W-1:0]  start_rm;
    logic [HASH_W-1:0]  rot_sum;
    logic [HASH_W-1:0]  rot_next;
    logic [HASH_W-1:0]  fin_sum;
    logic [HASH_W-1:0]  fin_next;
    logic               out_free;

    assign out_valid     = out_valid_reg;
    assign combined_hash = combined_hash_reg;
    assign hash_error    = hash_error_reg;
    assign out_free      = !out_valid_reg || !out_stall;
    assign rd_en         = (state_reg == S_IDLE) && rd_valid;

    // Low 64 bits of a 64x64 product: lo*lo, then the two cross terms into the upper half.
    always_comb
    begin
        unique case (mstep_reg)
            2'd0:    begin mul_x = op_a_reg[31:0];  mul_y = op_b_reg[31:0];  end
            2'd1:    begin mul_x = op_a_reg[63:32]; mul_y = op_b_reg[31:0];  end
            default: begin mul_x = op_a_reg[31:0];  mul_y = op_b_reg[63:32]; end
        endcase
        mul_p = {32'b0, mul_x} * {32'b0, mul_y};
        if (mstep_reg == 2'd0)
            prod_next = mul_p;
        else
            prod_next = {prod_reg[63:32] + mul_p[31:0], prod_reg[31:0]};
    end

    always_comb
    begin
        start_acc = rd_word.first ? start_value(hash_mode) : acc_reg;
        start_rm  = rd_word.first ? legacy_multiplier : rm_reg;
        rot_sum   = acc_reg + prod_reg;
        rot_next  = {rot_sum[32:0], rot_sum[63:33]};
        if (hash_mode == MODE_XX)
        begin
            fin_sum  = acc_reg + ({52'b0, count_reg} ^ (XX_P5 ^ XX_LEN_MIX));
            fin_next = (fin_sum == ALL_ONES) ? XX_ALT : fin_sum;
        end
        else
        begin
            fin_sum  = acc_reg + LG_ADD;
            fin_next = (fin_sum == ALL_ONES) ? ALL_ONES - 64'd1 : fin_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mstep_reg      <= '0;
            second_mul_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // S_FIN reloads the valid itself when the output frees up
            if (out_valid_reg && !out_stall && state_reg != S_FIN)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (rd_valid)
                    begin
                        last_reg  <= rd_word.last;
                        // an empty record ignores its lane, error flag included
                        err_reg   <= rd_word.err && !rd_word.empty_rec;
                        count_reg <= rd_word.count;
                        if (rd_word.empty_rec)
                        begin
                            acc_reg   <= start_value(hash_mode);
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            mstep_reg      <= '0;
                            second_mul_reg <= 1'b0;
                            state_reg      <= S_MUL;
                            if (hash_mode == MODE_XX)
                            begin
                                acc_reg  <= start_acc;
                                rm_reg   <= start_rm;
                                op_a_reg <= rd_word.lane;
                                op_b_reg <= XX_P2;
                            end
                            else
                            begin
                                op_a_reg <= start_acc ^ rd_word.lane;
                                op_b_reg <= start_rm;
                                rm_reg   <= start_rm + LG_STEP + {51'b0, rd_word.left, 1'b0};
                            end
                        end
                    end
                end

                S_MUL:
                begin
                    prod_reg <= prod_next;
                    if (mstep_reg == MSTEP_LAST)
                    begin
                        mstep_reg <= '0;
                        if (hash_mode == MODE_XX && !second_mul_reg)
                            state_reg <= S_ROT;
                        else
                        begin
                            acc_reg   <= prod_next;
                            state_reg <= last_reg ? S_FIN : S_IDLE;
                        end
                    end
                    else
                        mstep_reg <= mstep_reg + 1'b1;
                end

                S_ROT:
                begin
                    op_a_reg       <= rot_next;
                    op_b_reg       <= XX_P1;
                    second_mul_reg <= 1'b1;
                    mstep_reg      <= '0;
                    state_reg      <= S_MUL;
                end

                S_FIN:
                begin
                    // hold until the output register frees up
                    if (out_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        combined_hash_reg <= err_reg ? ALL_ONES : fin_next;
                        hash_error_reg    <= err_reg;
                        state_reg         <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/core/tuple_hash_combiner.sv
// Top level of the tuple hash combiner: configuration registers and front/queue/back.
`timescale 1ns / 1ps

// Folds 64-bit element hashes, one per input word, into one 64-bit record hash.
// Input channel: in_valid/in_stall with lane_hash and element_count; a word is
// taken when in_valid is high and in_stall low. element_count 0 is an empty
// record and gives a result at once. One result word per record leaves on
// out_valid/out_stall with combined_hash and hash_error.
// Config: APB-style, hash_mode at byte 0x0, legacy_multiplier at 0x8, pready
// always high; write only while no record word is still in flight.
// Datapath: each 64-bit product is built from lo*lo and then the two cross
// terms on one shared 32x32 multiplier. An element takes two products and a
// rotate in xxHash mode and one product in legacy mode; the last element of a
// record then passes a finish step before its result, and an empty record
// goes straight to that finish step. A two-word queue lets the front accept
// while the back is busy or a result waits.
// Reset: clears the record position, the queue and the output valid, and loads
// hash_mode 0 and legacy_multiplier 1000003.
// When out_stall is high the result word holds; the back holds its next
// result, the queue fills and in_stall rises.
module tuple_hash_combiner
    import thc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [HASH_W-1:0]  lane_hash,
    input  logic [COUNT_W-1:0] element_count,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [HASH_W-1:0]  combined_hash,
    output logic               hash_error,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    logic              hash_mode_reg;
    logic [HASH_W-1:0] legacy_multiplier_reg;

    logic      wr_valid;
    thc_word_t wr_word;
    logic      wr_full;
    logic      rd_valid;
    thc_word_t rd_word;
    logic      rd_en;

    assign pready = 1'b1;
    assign prdata = paddr[3] ? legacy_multiplier_reg : {63'b0, hash_mode_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_mode_reg         <= MODE_XX;
            legacy_multiplier_reg <= 64'd1000003;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[3])
                legacy_multiplier_reg <= pwdata;
            else
                hash_mode_reg <= pwdata[0];
        end
    end

    thc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .lane_hash     (lane_hash),
        .element_count (element_count),
        .wr_valid      (wr_valid),
        .wr_word       (wr_word),
        .wr_full       (wr_full)
    );

    thc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (wr_valid),
        .wr_word  (wr_word),
        .wr_full  (wr_full),
        .rd_valid (rd_valid),
        .rd_word  (rd_word),
        .rd_en    (rd_en)
    );

    thc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .hash_mode         (hash_mode_reg),
        .legacy_multiplier (legacy_multiplier_reg),
        .rd_valid          (rd_valid),
        .rd_word           (rd_word),
        .rd_en             (rd_en),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .combined_hash     (combined_hash),
        .hash_error        (hash_error)
    );

endmodule
